/* hw/rtl/ocs_pkg.sv */
`timescale 1ns / 1ps

package ocs_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_ocs_op;

    typedef struct packed {
        logic [WORD_W-1:0] popped_value;
        logic              underflow;
        logic [WORD_W-1:0] top_value;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
    } t_ocs_result;

endpackage

/* hw/rtl/ocs_ram.sv */
`timescale 1ns / 1ps

module ocs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/ocs_core.sv */
`timescale 1ns / 1ps

module ocs_core
    import ocs_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_ocs_op                  i_op,
    input  logic [DATA_WIDTH-1:0]    i_value,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_ocs_result              o_res,
    output logic                     o_ram_we,
    output logic [$clog2(DEPTH)-1:0] o_ram_wr_addr,
    output logic [DATA_WIDTH-1:0]    o_ram_wr_data,
    output logic [$clog2(DEPTH)-1:0] o_ram_rd_addr,
    input  logic [DATA_WIDTH-1:0]    i_ram_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_slot, n_slot;
    logic [CW-1:0]     r_count, n_count;
    logic [DATA_WIDTH-1:0] r_top, n_top;
    logic              r_res_valid, n_res_valid;
    t_ocs_result       r_res, n_res;

    logic              accept;
    logic [AW-1:0]     slot_inc, slot_dec, slot_dec2;

    assign slot_inc  = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
    assign slot_dec  = (r_slot == '0) ? LAST_SLOT : r_slot - 1'b1;
    assign slot_dec2 = (slot_dec == '0) ? LAST_SLOT : slot_dec - 1'b1;

    assign o_ready = (r_state == S_IDLE) && !r_res_valid;
    assign accept  = i_valid && o_ready;

    // the entry under the top is fetched on every cycle; a pop uses it
    assign o_ram_rd_addr = slot_dec2;
    assign o_ram_wr_addr = r_slot;
    assign o_ram_wr_data = i_value;

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_count     = r_count;
        n_top       = r_top;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        o_ram_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_PUSH: begin
                            o_ram_we = 1'b1;
                            n_slot   = slot_inc;
                            // a full stack overwrites its oldest item
                            n_count  = (r_count == FULL_CNT) ? r_count : r_count + 1'b1;
                            n_top    = i_value;
                            n_res.popped_value = '0;
                            n_res.underflow    = 1'b0;
                            n_res.top_value    = WORD_W'(i_value);
                            n_res.entry_count  = CNT_W'(n_count);
                            n_res.is_empty     = 1'b0;
                            n_res_valid        = 1'b1;
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_res.popped_value = '0;
                                n_res.underflow    = 1'b1;
                                n_res.top_value    = '0;
                                n_res.entry_count  = '0;
                                n_res.is_empty     = 1'b1;
                                n_res_valid        = 1'b1;
                            end else begin
                                n_slot  = slot_dec;
                                n_count = r_count - 1'b1;
                                n_res.popped_value = WORD_W'(r_top);
                                n_res.underflow    = 1'b0;
                                n_res.top_value    = '0;
                                n_res.entry_count  = CNT_W'(n_count);
                                n_res.is_empty     = (n_count == '0);
                                if (n_count == '0) begin
                                    n_res_valid = 1'b1;
                                end else begin
                                    n_state = S_READ;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_top           = i_ram_rd_data;
                n_res.top_value = WORD_W'(i_ram_rd_data);
                n_res_valid     = 1'b1;
                n_state         = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* hw/rtl/overwriting_circular_stack_unit.sv */
`timescale 1ns / 1ps
// Channel  Valid    Ready    Payload
// input    i_valid  o_ready  i_op, i_push_value
// output   o_valid  i_ready  o_popped_value, o_underflow, o_top_value,
//                            o_entry_count, o_is_empty
//
// A push, and a pop that empties the stack or underflows, passes its result
// through the core's result register and the output register; the next item
// is taken once the core's result has moved on. A pop that leaves entries
// first reads the new top from the store's registered read port.
// Reset (i_rst_n low, synchronous) empties the stack; the store is not cleared.
// One finished item waits in the output register while the next is worked on;
// the input is held off while the core's result waits for that register.

module overwriting_circular_stack_unit
    import ocs_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [WORD_W-1:0] i_push_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_popped_value,
    output logic              o_underflow,
    output logic [WORD_W-1:0] o_top_value,
    output logic [CNT_W-1:0]  o_entry_count,
    output logic              o_is_empty
);

    localparam int AW = $clog2(DEPTH);

    logic                  s_res_valid;
    logic                  s_res_ready;
    t_ocs_result           s_res;
    logic                  s_ram_we;
    logic [AW-1:0]         s_ram_wr_addr;
    logic [DATA_WIDTH-1:0] s_ram_wr_data;
    logic [AW-1:0]         s_ram_rd_addr;
    logic [DATA_WIDTH-1:0] s_ram_rd_data;

    logic                  r_out_valid;
    t_ocs_result           r_out;

    ocs_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (t_ocs_op'(i_op)),
        .i_value       (DATA_WIDTH'(i_push_value)),
        .o_res_valid   (s_res_valid),
        .i_res_ready   (s_res_ready),
        .o_res         (s_res),
        .o_ram_we      (s_ram_we),
        .o_ram_wr_addr (s_ram_wr_addr),
        .o_ram_wr_data (s_ram_wr_data),
        .o_ram_rd_addr (s_ram_rd_addr),
        .i_ram_rd_data (s_ram_rd_data)
    );

    ocs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (s_ram_we),
        .i_wr_addr (s_ram_wr_addr),
        .i_wr_data (s_ram_wr_data),
        .i_rd_addr (s_ram_rd_addr),
        .o_rd_data (s_ram_rd_data)
    );

    // advance the core's result whenever the output register is free or draining
    assign s_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_res_ready) begin
            r_out_valid <= s_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res_ready && s_res_valid) begin
            r_out <= s_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_popped_value = r_out.popped_value;
    assign o_underflow    = r_out.underflow;
    assign o_top_value    = r_out.top_value;
    assign o_entry_count  = r_out.entry_count;
    assign o_is_empty     = r_out.is_empty;

    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_valid && !s_res_ready |=> s_res_valid && $stable(s_res))
        else $error("core result dropped while output register full");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_valid |-> !o_ready)
        else $error("item taken while a result waits in the core");

    a_underflow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_underflow |-> o_is_empty && (o_popped_value == '0))
        else $error("underflow item reports a value or a non-empty stack");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> (o_top_value == '0) && (o_entry_count == '0))
        else $error("empty stack reports a top value or count");

endmodule

/* dv/ocs_checker.sv */
`timescale 1ns / 1ps

module ocs_checker
    import ocs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_op,
    input  logic [WORD_W-1:0] i_push_value,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_popped_value,
    input  logic              i_underflow,
    input  logic [WORD_W-1:0] i_top_value,
    input  logic [CNT_W-1:0]  i_entry_count,
    input  logic              i_is_empty,
    output int unsigned       o_fail_count,
    output int unsigned       o_pending
);

    logic [WORD_W-1:0] stack_words [DEPTH];
    int unsigned       push_slot;
    int unsigned       held;
    int unsigned       results_seen;
    t_ocs_result       expected_q[$];

    // Apply one operation to the shadow stack and return what the block should report.
    function automatic t_ocs_result step_stack(input t_ocs_op op, input logic [WORD_W-1:0] word);
        t_ocs_result r;
        r = '0;
        if (op == OP_PUSH) begin
            stack_words[push_slot] = word;
            push_slot = (push_slot + 1) % DEPTH;
            // full stack: oldest entry is overwritten, count holds
            if (held < DEPTH)
                held = held + 1;
        end else if (held == 0) begin
            r.underflow = 1'b1;
        end else begin
            push_slot = (push_slot + DEPTH - 1) % DEPTH;
            r.popped_value = stack_words[push_slot];
            held = held - 1;
        end
        if (held != 0)
            r.top_value = stack_words[(push_slot + DEPTH - 1) % DEPTH];
        r.entry_count = CNT_W'(held);
        r.is_empty    = (held == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_ocs_result got;
        t_ocs_result want;
        if (!i_rst_n) begin
            push_slot = 0;
            held      = 0;
            expected_q.delete();
        end else begin
            // compare before predicting so a same-edge item can never cover a stray result
            if (i_out_valid && i_out_ready) begin
                got = {i_popped_value, i_underflow, i_top_value, i_entry_count, i_is_empty};
                results_seen = results_seen + 1;
                if (expected_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10)
                        $display("result %0d: unexpected, popped=%h uf=%b top=%h count=%0d empty=%b",
                                 results_seen, got.popped_value, got.underflow, got.top_value,
                                 got.entry_count, got.is_empty);
                end else begin
                    want = expected_q.pop_front();
                    if (got.popped_value !== want.popped_value || got.underflow !== want.underflow ||
                        got.top_value !== want.top_value || got.entry_count !== want.entry_count ||
                        got.is_empty !== want.is_empty) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("result %0d: expected popped=%h uf=%b top=%h count=%0d empty=%b",
                                     results_seen, want.popped_value, want.underflow,
                                     want.top_value, want.entry_count, want.is_empty);
                            $display("result %0d: actual   popped=%h uf=%b top=%h count=%0d empty=%b",
                                     results_seen, got.popped_value, got.underflow,
                                     got.top_value, got.entry_count, got.is_empty);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(step_stack(t_ocs_op'(i_op), i_push_value));
        end
        o_pending = expected_q.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ocs_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int STALL_LIMIT = 4000;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic              i_op         = 1'b0;
    logic [WORD_W-1:0] i_push_value = '0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    logic [WORD_W-1:0] o_popped_value;
    logic              o_underflow;
    logic [WORD_W-1:0] o_top_value;
    logic [CNT_W-1:0]  o_entry_count;
    logic              o_is_empty;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned stall_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    overwriting_circular_stack_unit #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (WORD_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_popped_value (o_popped_value),
        .o_underflow    (o_underflow),
        .o_top_value    (o_top_value),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty)
    );

    ocs_checker #(
        .DEPTH (STACK_DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_op           (i_op),
        .i_push_value   (i_push_value),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_popped_value (o_popped_value),
        .i_underflow    (o_underflow),
        .i_top_value    (o_top_value),
        .i_entry_count  (o_entry_count),
        .i_is_empty     (o_is_empty),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= rx_idle_pct);

    // Abort when neither channel moves an item for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_item(input t_ocs_op op, input logic [WORD_W-1:0] word);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_push_value <= word;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Bursts of pushes and pops drive the stack to full, past full and down to underflow.
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned mode;
        sent = 0;
        while (sent < count) begin
            mode  = $urandom_range(3);
            burst = (mode < 2) ? $urandom_range(20, 1) : $urandom_range(12, 1);
            repeat (burst) begin
                case (mode)
                    0:       send_item(OP_PUSH, pick_word());
                    1:       send_item(OP_POP, pick_word());
                    default: send_item(t_ocs_op'($urandom_range(1)), pick_word());
                endcase
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty stack, extreme words, then fill past full and back off
        send_item(OP_POP, '1);
        send_item(OP_PUSH, '1);
        send_item(OP_PUSH, '0);
        send_item(OP_POP, '0);
        send_item(OP_POP, '0);
        send_item(OP_POP, '0);
        for (int i = 0; i < STACK_DEPTH + 1; i++)
            send_item(OP_PUSH, 32'hA5A5_0000 | i);
        send_item(OP_POP, '0);
        send_item(OP_POP, '1);

        tx_idle_pct = 10;
        rx_idle_pct = 81;
        run_random(217);
        tx_idle_pct = 81;
        rx_idle_pct = 10;
        run_random(217);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(217);
        i_valid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ocs_pkg.sv
hw/rtl/ocs_ram.sv
hw/rtl/ocs_core.sv
hw/rtl/overwriting_circular_stack_unit.sv
dv/ocs_checker.sv
dv/tb_top.sv
